/* src/rgb_to_ycbcr420_converter_top_macros.svh */
// Assertion macros for the RGB to YCbCr 4:2:0 converter.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef RGB_TO_YCBCR420_CONVERTER_TOP_MACROS_SVH
`define RGB_TO_YCBCR420_CONVERTER_TOP_MACROS_SVH
`ifndef SYNTH
`define YCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ycc check failed");
`define YCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ycc check failed");
`else
`define YCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define YCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* src/ycc_pkg.sv */
// Shared types, constants and the sample function of the YCbCr converter.
// No dependencies.
package ycc_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int PIX_W          = 8;
  localparam int SIZE_W         = 13;
  localparam int STRIDE_W       = 14;
  localparam int CFG_DATA_W     = 14;
  localparam int CFG_IDX_W      = 3;
  localparam int LUMA_ADDR_W    = 25;
  localparam int CHROMA_ADDR_W  = 24;

  localparam int Q_BITS         = 16;
  localparam int COEF_W         = 18;
  localparam int SUM_W          = 30;

  // Q16 weights, rounded to nearest
  localparam logic signed [COEF_W-1:0] Y_KR  = 18'sd16843;
  localparam logic signed [COEF_W-1:0] Y_KG  = 18'sd33030;
  localparam logic signed [COEF_W-1:0] Y_KB  = 18'sd6423;
  localparam logic signed [COEF_W-1:0] CB_KR = -18'sd9699;
  localparam logic signed [COEF_W-1:0] CB_KG = -18'sd19071;
  localparam logic signed [COEF_W-1:0] CB_KB = 18'sd28770;
  localparam logic signed [COEF_W-1:0] CR_KR = 18'sd28770;
  localparam logic signed [COEF_W-1:0] CR_KG = -18'sd24117;
  localparam logic signed [COEF_W-1:0] CR_KB = -18'sd4653;

  localparam logic signed [SUM_W-1:0] Y_OFF = SUM_W'(16 <<< Q_BITS);
  localparam logic signed [SUM_W-1:0] C_OFF = SUM_W'(128 <<< Q_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_LUMA_STRIDE  = 3'd2,
    REG_CB_STRIDE    = 3'd3,
    REG_CR_STRIDE    = 3'd4
  } ycc_reg_t;

  typedef struct packed {
    logic [SIZE_W-1:0]   frame_width;
    logic [SIZE_W-1:0]   frame_height;
    logic [STRIDE_W-1:0] luma_stride;
    logic [STRIDE_W-1:0] cb_stride;
    logic [STRIDE_W-1:0] cr_stride;
  } ycc_cfg_t;

  typedef struct packed {
    logic chroma;
    logic last;
  } ycc_flags_t;

  // Weighted Q16 sum, truncated toward zero, clamped to 0..255
  function automatic logic [PIX_W-1:0] ycc_sample(
    input logic signed [COEF_W-1:0] kr,
    input logic signed [COEF_W-1:0] kg,
    input logic signed [COEF_W-1:0] kb,
    input logic signed [SUM_W-1:0]  off,
    input logic [PIX_W-1:0]         r,
    input logic [PIX_W-1:0]         g,
    input logic [PIX_W-1:0]         b
  );
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] q;
    logic [PIX_W-1:0]        res;
    s = SUM_W'(kr) * SUM_W'($signed({1'b0, r}))
      + SUM_W'(kg) * SUM_W'($signed({1'b0, g}))
      + SUM_W'(kb) * SUM_W'($signed({1'b0, b}))
      + off;
    q = s >>> Q_BITS;
    if (s < 0) begin
      res = '0;
    end else if (q > SUM_W'(255)) begin
      res = '1;
    end else begin
      res = q[PIX_W-1:0];
    end
    return res;
  endfunction

endpackage

/* src/ycc_if.sv */
// Stream interfaces of the converter: RGB pixel in, YCbCr result out.
// Depends on ycc_pkg.
interface ycc_pix_if;
  logic                       valid;
  logic                       ready;
  logic [ycc_pkg::PIX_W-1:0]  red;
  logic [ycc_pkg::PIX_W-1:0]  green;
  logic [ycc_pkg::PIX_W-1:0]  blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface ycc_res_if;
  logic                               valid;
  logic                               ready;
  logic [ycc_pkg::PIX_W-1:0]          luma;
  logic [ycc_pkg::LUMA_ADDR_W-1:0]    luma_address;
  logic                               chroma_valid;
  logic [ycc_pkg::PIX_W-1:0]          chroma_blue;
  logic [ycc_pkg::PIX_W-1:0]          chroma_red;
  logic [ycc_pkg::CHROMA_ADDR_W-1:0]  cb_address;
  logic [ycc_pkg::CHROMA_ADDR_W-1:0]  cr_address;
  logic                               frame_last;

  modport source (output valid, luma, luma_address, chroma_valid, chroma_blue,
                  chroma_red, cb_address, cr_address, frame_last, input ready);
  modport sink   (input valid, luma, luma_address, chroma_valid, chroma_blue,
                  chroma_red, cb_address, cr_address, frame_last, output ready);
endinterface

/* src/ycc_cfg.sv */
// Configuration register file: frame size and plane strides.
// Depends on ycc_pkg.
module ycc_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              we_i,
  input  logic [ycc_pkg::CFG_IDX_W-1:0]     index_i,
  input  logic [ycc_pkg::CFG_DATA_W-1:0]    wdata_i,
  output ycc_pkg::ycc_cfg_t                 cfg_o
);

  ycc_pkg::ycc_cfg_t cfg_r;
  ycc_pkg::ycc_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (we_i) begin
      case (index_i)
        ycc_pkg::REG_FRAME_WIDTH:  cfg_nxt.frame_width  = wdata_i[ycc_pkg::SIZE_W-1:0];
        ycc_pkg::REG_FRAME_HEIGHT: cfg_nxt.frame_height = wdata_i[ycc_pkg::SIZE_W-1:0];
        ycc_pkg::REG_LUMA_STRIDE:  cfg_nxt.luma_stride  = wdata_i[ycc_pkg::STRIDE_W-1:0];
        ycc_pkg::REG_CB_STRIDE:    cfg_nxt.cb_stride    = wdata_i[ycc_pkg::STRIDE_W-1:0];
        ycc_pkg::REG_CR_STRIDE:    cfg_nxt.cr_stride    = wdata_i[ycc_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= ycc_pkg::SIZE_W'(640);
      cfg_r.frame_height <= ycc_pkg::SIZE_W'(480);
      cfg_r.luma_stride  <= ycc_pkg::STRIDE_W'(640);
      cfg_r.cb_stride    <= ycc_pkg::STRIDE_W'(320);
      cfg_r.cr_stride    <= ycc_pkg::STRIDE_W'(320);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

/* src/ycc_raster.sv */
// Raster position counters: column and row, with frame-size limiting.
// Depends on ycc_pkg.
module ycc_raster #(
  parameter int MAX_WIDTH  = ycc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ycc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ycc_pkg::ycc_cfg_t             cfg_i,
  input  logic                          adv_i,
  output logic [$clog2(MAX_WIDTH)-1:0]  col_o,
  output logic [$clog2(MAX_HEIGHT)-1:0] row_o,
  output ycc_pkg::ycc_flags_t           flags_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [WW-1:0] w_lim;
  logic [HW-1:0] h_lim;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic          col_wrap, row_wrap;

  // zero counts as one, oversize clamps to the maximum
  always_comb begin
    if (cfg_i.frame_width == '0) begin
      w_lim = WW'(1);
    end else if (int'(cfg_i.frame_width) > MAX_WIDTH) begin
      w_lim = WW'(MAX_WIDTH);
    end else begin
      w_lim = WW'(cfg_i.frame_width);
    end
    if (cfg_i.frame_height == '0) begin
      h_lim = HW'(1);
    end else if (int'(cfg_i.frame_height) > MAX_HEIGHT) begin
      h_lim = HW'(MAX_HEIGHT);
    end else begin
      h_lim = HW'(cfg_i.frame_height);
    end
  end

  assign col_inc  = (CW+1)'(col_r) + (CW+1)'(1);
  assign row_inc  = (RW+1)'(row_r) + (RW+1)'(1);
  assign col_wrap = col_inc >= (CW+1)'(w_lim);
  assign row_wrap = row_inc >= (RW+1)'(h_lim);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (adv_i) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_wrap ? '0 : row_inc[RW-1:0];
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col_o          = col_r;
  assign row_o          = row_r;
  assign flags_o.chroma = !col_r[0] && !row_r[0];
  assign flags_o.last   = ((CW+1)'(col_r) == (CW+1)'(w_lim) - (CW+1)'(1))
                       && ((RW+1)'(row_r) == (RW+1)'(h_lim) - (RW+1)'(1));

endmodule

/* src/ycc_csc.sv */
// BT.601 studio-range color matrix, Q16 weights by constants.
// Depends on ycc_pkg.
module ycc_csc (
  input  logic [ycc_pkg::PIX_W-1:0] red_i,
  input  logic [ycc_pkg::PIX_W-1:0] green_i,
  input  logic [ycc_pkg::PIX_W-1:0] blue_i,
  output logic [ycc_pkg::PIX_W-1:0] y_o,
  output logic [ycc_pkg::PIX_W-1:0] cb_o,
  output logic [ycc_pkg::PIX_W-1:0] cr_o
);

  assign y_o  = ycc_pkg::ycc_sample(ycc_pkg::Y_KR, ycc_pkg::Y_KG, ycc_pkg::Y_KB,
                                    ycc_pkg::Y_OFF, red_i, green_i, blue_i);
  assign cb_o = ycc_pkg::ycc_sample(ycc_pkg::CB_KR, ycc_pkg::CB_KG, ycc_pkg::CB_KB,
                                    ycc_pkg::C_OFF, red_i, green_i, blue_i);
  assign cr_o = ycc_pkg::ycc_sample(ycc_pkg::CR_KR, ycc_pkg::CR_KG, ycc_pkg::CR_KB,
                                    ycc_pkg::C_OFF, red_i, green_i, blue_i);

endmodule

/* src/ycc_addr.sv */
// Plane address generator: row times stride plus column for luma, halved row and column for the chroma planes.
// Depends on ycc_pkg.
module ycc_addr #(
  parameter int MAX_WIDTH  = ycc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ycc_pkg::MAX_HEIGHT_DEF
) (
  input  ycc_pkg::ycc_cfg_t                  cfg_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]       col_i,
  input  logic [$clog2(MAX_HEIGHT)-1:0]      row_i,
  output logic [ycc_pkg::LUMA_ADDR_W-1:0]    luma_addr_o,
  output logic [ycc_pkg::CHROMA_ADDR_W-1:0]  cb_addr_o,
  output logic [ycc_pkg::CHROMA_ADDR_W-1:0]  cr_addr_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int PW = RW + ycc_pkg::STRIDE_W;
  localparam int MW = (PW > CW) ? PW : CW;
  localparam int XW = (MW + 1 > ycc_pkg::LUMA_ADDR_W) ? MW + 1 : ycc_pkg::LUMA_ADDR_W;

  logic [RW-1:0] half_row;
  logic [CW-1:0] half_col;
  logic [PW-1:0] l_prod, cb_prod, cr_prod;
  logic [XW-1:0] l_sum, cb_sum, cr_sum;

  assign half_row = row_i >> 1;
  assign half_col = col_i >> 1;

  assign l_prod  = PW'(row_i) * PW'(cfg_i.luma_stride);
  assign cb_prod = PW'(half_row) * PW'(cfg_i.cb_stride);
  assign cr_prod = PW'(half_row) * PW'(cfg_i.cr_stride);

  assign l_sum  = XW'(l_prod) + XW'(col_i);
  assign cb_sum = XW'(cb_prod) + XW'(half_col);
  assign cr_sum = XW'(cr_prod) + XW'(half_col);

  // addresses wrap to their field widths
  assign luma_addr_o = l_sum[ycc_pkg::LUMA_ADDR_W-1:0];
  assign cb_addr_o   = cb_sum[ycc_pkg::CHROMA_ADDR_W-1:0];
  assign cr_addr_o   = cr_sum[ycc_pkg::CHROMA_ADDR_W-1:0];

endmodule

/* src/rgb_to_ycbcr420_converter_top.sv */
// Top level of the RGB to YCbCr 4:2:0 converter: input register, color matrix,
// address generator, result register. Depends on ycc_pkg, ycc_if and all ycc_* modules.
//
// Converts a raster-order stream of 8-bit RGB pixels to studio-range BT.601
// YCbCr. Every pixel beat on in_pix yields exactly one result beat on out_res
// carrying luma and its luma-plane address; on even rows and even columns the
// beat also carries Cb, Cr and their plane addresses (top-left sample of each
// 2x2 block) with chroma_valid set, else those fields read 0. frame_last flags
// the bottom-right pixel of the frame. Throughput is one pixel per clock while
// the receiver keeps ready high; pixels pass the input register, then the result
// register, with the color matrix and the three stride multipliers in the single
// logic stage between them. The result register lets the block take a new pixel
// while a finished result waits. Registers (cfg_index): 0 frame_width, 1 frame_height,
// 2 luma_stride, 3 cb_stride, 4 cr_stride; write them only while the stream is
// idle. Raster counters restart at reset and after the last pixel of a frame.
module rgb_to_ycbcr420_converter_top #(
  parameter int MAX_WIDTH  = ycc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ycc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ycc_pix_if.sink                           in_pix,
  ycc_res_if.source                         out_res,
  input  logic                              cfg_we,
  input  logic [ycc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ycc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  `include "rgb_to_ycbcr420_converter_top_macros.svh"

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  ycc_pkg::ycc_cfg_t   cfg;
  ycc_pkg::ycc_flags_t pos_flags;
  logic [CW-1:0]       pos_col;
  logic [RW-1:0]       pos_row;

  // handshake
  logic in_acc;
  logic out_adv;   // result register can take a new beat
  logic s1_load;

  // input stage
  logic                      s1_v_r, s1_v_nxt;
  logic [ycc_pkg::PIX_W-1:0] s1_red_r, s1_green_r, s1_blue_r;
  logic [CW-1:0]             s1_col_r;
  logic [RW-1:0]             s1_row_r;
  ycc_pkg::ycc_flags_t       s1_flags_r;

  // combinational results of stage 1
  logic [ycc_pkg::PIX_W-1:0]         y_c, cb_c, cr_c;
  logic [ycc_pkg::LUMA_ADDR_W-1:0]   laddr_c;
  logic [ycc_pkg::CHROMA_ADDR_W-1:0] cbaddr_c, craddr_c;

  // result stage
  logic                              out_v_r, out_v_nxt;
  logic [ycc_pkg::PIX_W-1:0]         luma_r, cb_r, cr_r;
  logic [ycc_pkg::LUMA_ADDR_W-1:0]   laddr_r;
  logic [ycc_pkg::CHROMA_ADDR_W-1:0] cbaddr_r, craddr_r;
  logic                              chroma_r, last_r;

  ycc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .we_i    (cfg_we),
    .index_i (cfg_index),
    .wdata_i (cfg_wdata),
    .cfg_o   (cfg)
  );

  // counters step on each accepted pixel; position is sampled with the pixel
  ycc_raster #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_raster (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_i   (cfg),
    .adv_i   (in_acc),
    .col_o   (pos_col),
    .row_o   (pos_row),
    .flags_o (pos_flags)
  );

  // Flow control: result register frees up when empty or drained this cycle,
  // the input register when empty or moving forward.
  assign out_adv      = !out_v_r || out_res.ready;
  assign in_pix.ready = !s1_v_r || out_adv;
  assign in_acc       = in_pix.valid && in_pix.ready;
  assign s1_load      = out_adv && s1_v_r;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (out_adv) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_adv ? s1_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_red_r   <= in_pix.red;
      s1_green_r <= in_pix.green;
      s1_blue_r  <= in_pix.blue;
      s1_col_r   <= pos_col;
      s1_row_r   <= pos_row;
      s1_flags_r <= pos_flags;
    end
  end

  ycc_csc u_csc (
    .red_i   (s1_red_r),
    .green_i (s1_green_r),
    .blue_i  (s1_blue_r),
    .y_o     (y_c),
    .cb_o    (cb_c),
    .cr_o    (cr_c)
  );

  ycc_addr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_addr (
    .cfg_i       (cfg),
    .col_i       (s1_col_r),
    .row_i       (s1_row_r),
    .luma_addr_o (laddr_c),
    .cb_addr_o   (cbaddr_c),
    .cr_addr_o   (craddr_c)
  );

  // chroma fields are forced to zero off the 2x2 sampling grid
  always_ff @(posedge clk) begin
    if (s1_load) begin
      luma_r   <= y_c;
      laddr_r  <= laddr_c;
      chroma_r <= s1_flags_r.chroma;
      last_r   <= s1_flags_r.last;
      cb_r     <= s1_flags_r.chroma ? cb_c : '0;
      cr_r     <= s1_flags_r.chroma ? cr_c : '0;
      cbaddr_r <= s1_flags_r.chroma ? cbaddr_c : '0;
      craddr_r <= s1_flags_r.chroma ? craddr_c : '0;
    end
  end

  assign out_res.valid        = out_v_r;
  assign out_res.luma         = luma_r;
  assign out_res.luma_address = laddr_r;
  assign out_res.chroma_valid = chroma_r;
  assign out_res.chroma_blue  = cb_r;
  assign out_res.chroma_red   = cr_r;
  assign out_res.cb_address   = cbaddr_r;
  assign out_res.cr_address   = craddr_r;
  assign out_res.frame_last   = last_r;

  // an accepted pixel always occupies the input register next cycle
  `YCC_ASSERT_NXT(a_s1_fill, clk, rst_n, in_acc, s1_v_r)
  // last pixel of a frame restarts the raster at the origin
  `YCC_ASSERT_NXT(a_frame_wrap, clk, rst_n, in_acc && pos_flags.last, (pos_col == '0) && (pos_row == '0))
  // luma offset keeps Y at or above 16
  `YCC_ASSERT_IMP(a_luma_floor, clk, rst_n, out_v_r, luma_r >= 8'd16)
  // off-grid results carry no chroma
  `YCC_ASSERT_IMP(a_chroma_zero, clk, rst_n, out_v_r && !chroma_r, (cb_r == '0) && (cr_r == '0) && (cbaddr_r == '0) && (craddr_r == '0))

endmodule

/* bench/tb.sv */
// Self-checking bench for the RGB to YCbCr 4:2:0 converter top level.
// Depends on ycc_pkg, ycc_if and the converter RTL; drives pixel beats,
// mirrors the raster counters in a local model and checks every result beat.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ycc_pkg::*;

  // Block geometry and bench timing
  localparam int unsigned WIDTH_CAP     = 4096;
  localparam int unsigned HEIGHT_CAP    = 4096;
  localparam int          PIPE_LATENCY  = 2;     // input reg + result reg
  localparam int          HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int          QUIET_LIMIT   = 4000;  // cycles with no beat at all
  localparam int          RANDOM_PHASES = 8;
  localparam int          PHASE_ITEMS   = 110;
  localparam int          HOLD_PHASE    = 4;
  localparam int          PAUSE_PHASE   = 5;

  // Unmapped register index: a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  // BT.601 studio-range weights, Q16
  localparam int LUMA_R_Q16  = 16843;
  localparam int LUMA_G_Q16  = 33030;
  localparam int LUMA_B_Q16  = 6423;
  localparam int CB_R_Q16    = -9699;
  localparam int CB_G_Q16    = -19071;
  localparam int CB_B_Q16    = 28770;
  localparam int CR_R_Q16    = 28770;
  localparam int CR_G_Q16    = -24117;
  localparam int CR_B_Q16    = -4653;
  localparam int LUMA_BIAS   = 16;
  localparam int CHROMA_BIAS = 128;

  // One result beat, field for field as the output interface carries it
  typedef struct packed {
    logic [PIX_W-1:0]         luma;
    logic [LUMA_ADDR_W-1:0]   luma_addr;
    logic                     chroma;
    logic [PIX_W-1:0]         cb;
    logic [PIX_W-1:0]         cr;
    logic [CHROMA_ADDR_W-1:0] cb_addr;
    logic [CHROMA_ADDR_W-1:0] cr_addr;
    logic                     last;
  } ycc_beat_t;

  // Hand-typed expectation travelling with a pixel, used when known is set
  typedef struct packed {
    logic      known;
    ycc_beat_t beat;
  } typed_ycc_t;

  typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [PIX_W-1:0]       r;
    logic [PIX_W-1:0]       g;
    logic [PIX_W-1:0]       b;
    logic                   known;
    ycc_beat_t              want;
    logic [CFG_IDX_W-1:0]   idx;
    int unsigned            data;
  } script_row_t;

  typedef enum logic [1:0] {
    FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH
  } flow_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ycc_pix_if pix_ch ();
  ycc_res_if ycc_ch ();

  rgb_to_ycbcr420_converter_top #(
    .MAX_WIDTH (WIDTH_CAP),
    .MAX_HEIGHT(HEIGHT_CAP)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (pix_ch),
    .out_res  (ycc_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Expected result beats, oldest first, and the tags of offered pixels
  ycc_beat_t   pending_ycc[$];
  typed_ycc_t  typed_ycc[$];
  script_row_t script[$];

  // Local copy of the frame setup and raster position
  int unsigned frame_w, frame_h, luma_pitch, cb_pitch, cr_pitch;
  int unsigned col_pos, row_pos;

  int unsigned idle_pct  = 0;   // sender: chance of an idle cycle per beat
  int unsigned stall_pct = 0;   // receiver: chance of ready low per cycle
  bit          hold_req  = 1'b0;
  int          mismatches   = 0;
  int          quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Model of the converter
  // ---------------------------------------------------------------------

  // Q16 weighted sum, truncated toward zero, clamped to 0..255
  function automatic logic [PIX_W-1:0] q16_sample(input int kr, kg, kb, bias,
                                                  input logic [PIX_W-1:0] r, g, b);
    longint acc;
    longint q;
    acc = longint'(kr) * longint'(r) + longint'(kg) * longint'(g)
        + longint'(kb) * longint'(b) + longint'(bias) * 65536;
    if (acc < 0) q = -((-acc) >>> 16);
    else         q = acc >>> 16;
    if (q < 0)   q = 0;
    if (q > 255) q = 255;
    return q[PIX_W-1:0];
  endfunction

  // Zero counts as one, anything above the cap counts as the cap
  function automatic int unsigned cap_size(input int unsigned v, cap);
    if (v == 0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  // Converts one pixel at the current raster position, then steps the position
  function automatic ycc_beat_t convert_pixel(input logic [PIX_W-1:0] r, g, b);
    ycc_beat_t   o;
    int unsigned w;
    int unsigned h;
    logic [63:0] span;
    w = cap_size(frame_w, WIDTH_CAP);
    h = cap_size(frame_h, HEIGHT_CAP);
    o = '0;
    o.luma = q16_sample(LUMA_R_Q16, LUMA_G_Q16, LUMA_B_Q16, LUMA_BIAS, r, g, b);
    span = 64'(row_pos) * 64'(luma_pitch) + 64'(col_pos);
    o.luma_addr = span[LUMA_ADDR_W-1:0];
    // top-left sample of each 2x2 block carries chroma
    if (col_pos[0] == 1'b0 && row_pos[0] == 1'b0) begin
      o.chroma = 1'b1;
      o.cb = q16_sample(CB_R_Q16, CB_G_Q16, CB_B_Q16, CHROMA_BIAS, r, g, b);
      o.cr = q16_sample(CR_R_Q16, CR_G_Q16, CR_B_Q16, CHROMA_BIAS, r, g, b);
      span = 64'(row_pos >> 1) * 64'(cb_pitch) + 64'(col_pos >> 1);
      o.cb_addr = span[CHROMA_ADDR_W-1:0];
      span = 64'(row_pos >> 1) * 64'(cr_pitch) + 64'(col_pos >> 1);
      o.cr_addr = span[CHROMA_ADDR_W-1:0];
    end
    // a position left beyond a shrunk frame never matches, so no last flag
    o.last = (col_pos == w - 1) && (row_pos == h - 1);
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
    return o;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (got !== want) begin
      $display("[%0t] %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : ycc_monitor
    typed_ycc_t tag;
    ycc_beat_t  want;
    ycc_beat_t  got;
    ycc_beat_t  calc;
    logic       moved;
    if (!rst_n) begin
      frame_w    = 640;
      frame_h    = 480;
      luma_pitch = 640;
      cb_pitch   = 320;
      cr_pitch   = 320;
      col_pos    = 0;
      row_pos    = 0;
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      // register writes keep only the low bits of each register
      if (cfg_we) begin
        moved = 1'b1;
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_w    = cfg_wdata[SIZE_W-1:0];
          REG_FRAME_HEIGHT: frame_h    = cfg_wdata[SIZE_W-1:0];
          REG_LUMA_STRIDE:  luma_pitch = cfg_wdata[STRIDE_W-1:0];
          REG_CB_STRIDE:    cb_pitch   = cfg_wdata[STRIDE_W-1:0];
          REG_CR_STRIDE:    cr_pitch   = cfg_wdata[STRIDE_W-1:0];
          default: ;
        endcase
      end
      // result side first: a beat leaving now belongs to an earlier pixel
      if (ycc_ch.valid && ycc_ch.ready) begin
        moved = 1'b1;
        got = '{ycc_ch.luma, ycc_ch.luma_address, ycc_ch.chroma_valid,
                ycc_ch.chroma_blue, ycc_ch.chroma_red, ycc_ch.cb_address,
                ycc_ch.cr_address, ycc_ch.frame_last};
        if (pending_ycc.size() == 0) begin
          $display("[%0t] result beat with nothing expected: actual luma %0d, address %0d",
                   $time, got.luma, got.luma_addr);
          mismatches++;
        end else begin
          want = pending_ycc.pop_front();
          check_field("luma",         want.luma,      got.luma);
          check_field("luma_address", want.luma_addr, got.luma_addr);
          check_field("chroma_valid", want.chroma,    got.chroma);
          check_field("chroma_blue",  want.cb,        got.cb);
          check_field("chroma_red",   want.cr,        got.cr);
          check_field("cb_address",   want.cb_addr,   got.cb_addr);
          check_field("cr_address",   want.cr_addr,   got.cr_addr);
          check_field("frame_last",   want.last,      got.last);
        end
      end
      // pixel side: model always steps, typed values win where given
      if (pix_ch.valid && pix_ch.ready) begin
        moved = 1'b1;
        calc = convert_pixel(pix_ch.red, pix_ch.green, pix_ch.blue);
        tag = typed_ycc.pop_front();
        pending_ycc.push_back(tag.known ? tag.beat : calc);
      end
      if (moved) quiet_cycles = 0;
      else       quiet_cycles++;
    end
  end

  // Watchdog: too long without any beat means the block is hung
  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver: ready changes on the falling edge
  // ---------------------------------------------------------------------
  initial begin : ycc_receiver
    int unsigned hold_left;
    hold_left = 0;
    ycc_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        ycc_ch.ready <= 1'b0;
      end else begin
        ycc_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // Offers one pixel beat and returns on the falling edge after it is taken
  task automatic offer_pixel(input logic [PIX_W-1:0] r, g, b,
                             input logic known, input ycc_beat_t want);
    while ($urandom_range(99) < idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(negedge clk);
    end
    typed_ycc.push_back('{known, want});
    pix_ch.valid <= 1'b1;
    pix_ch.red   <= r;
    pix_ch.green <= g;
    pix_ch.blue  <= b;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering and waits until every result beat is back
  task automatic drain_pipe();
    pix_ch.valid <= 1'b0;
    while (pending_ycc.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  // One write per cycle; the caller drops cfg_we after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(negedge clk);
  endtask

  task automatic program_frame(input int unsigned w, h, lp, cbp, crp);
    drain_pipe();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_LUMA_STRIDE, lp);
    write_reg(REG_CB_STRIDE, cbp);
    write_reg(REG_CR_STRIDE, crp);
    cfg_we <= 1'b0;
  endtask

  function automatic void add_px(input logic [PIX_W-1:0] r, g, b);
    script.push_back('{ROW_PIXEL, r, g, b, 1'b0, '0, REG_FRAME_WIDTH, 0});
  endfunction

  function automatic void add_known(input logic [PIX_W-1:0] r, g, b, input ycc_beat_t want);
    script.push_back('{ROW_PIXEL, r, g, b, 1'b1, want, REG_FRAME_WIDTH, 0});
  endfunction

  function automatic void add_wr(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    script.push_back('{ROW_WRITE, 8'h00, 8'h00, 8'h00, 1'b0, '0, idx, data});
  endfunction

  // Mostly tiny frames so frames close often; some oversize and zero
  function automatic int unsigned pick_size();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(9, 1);
    if (roll < 85) return $urandom_range(16383);
    case (roll % 6)
      0:       return 0;
      1:       return 1;
      2:       return 4096;
      3:       return 4097;
      4:       return 8192;
      default: return 16383;
    endcase
  endfunction

  function automatic int unsigned pick_stride();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return $urandom_range(16383);
    case (roll % 5)
      0:       return 0;
      1:       return 1;
      2:       return 8191;
      3:       return 8192;
      default: return 16383;
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] pick_channel();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return 8'h00;
    if (roll < 20) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    logic       prev_write;
    flow_mode_t mode;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_FRAME_WIDTH;
    cfg_wdata    = '0;
    pix_ch.valid = 1'b0;
    pix_ch.red   = '0;
    pix_ch.green = '0;
    pix_ch.blue  = '0;

    // Reset setup 640x480: black and white corners, primaries, bit patterns.
    // Black at the origin: luma 16, neutral chroma at address 0.
    add_known(8'h00, 8'h00, 8'h00, '{8'd16, 25'd0, 1'b1, 8'd128, 8'd128, 24'd0, 24'd0, 1'b0});
    // White on an odd column: luma 235, chroma fields forced to zero
    add_known(8'hFF, 8'hFF, 8'hFF, '{8'd235, 25'd1, 1'b0, 8'd0, 8'd0, 24'd0, 24'd0, 1'b0});
    add_px(8'hFF, 8'h00, 8'h00);
    add_px(8'h00, 8'hFF, 8'h00);
    add_px(8'h00, 8'h00, 8'hFF);
    add_px(8'hFF, 8'hFF, 8'h00);
    add_px(8'h00, 8'hFF, 8'hFF);
    add_px(8'hAA, 8'h55, 8'hAA);
    add_px(8'h55, 8'hAA, 8'h55);
    // Shrink to 3x2 mid-row: column 9 lies past the new width, then a
    // full second row closes the frame. Spare index write must be ignored.
    add_wr(REG_FRAME_WIDTH, 3);
    add_wr(REG_FRAME_HEIGHT, 2);
    add_wr(REG_SPARE, 16383);
    add_px(8'h12, 8'h34, 8'h56);
    add_px(8'h01, 8'h02, 8'h03);
    add_px(8'hFE, 8'hFD, 8'hFC);
    add_px(8'h80, 8'h7F, 8'h80);
    add_px(8'h7F, 8'h80, 8'h7F);
    // Zero width, and a height whose low 13 bits are zero: a 1x1 frame,
    // so after the wrap every pixel is the origin and the last one
    add_wr(REG_FRAME_WIDTH, 0);
    add_wr(REG_FRAME_HEIGHT, 8192);
    add_px(8'h01, 8'h02, 8'h03);
    add_known(8'h00, 8'h00, 8'h00, '{8'd16, 25'd0, 1'b1, 8'd128, 8'd128, 24'd0, 24'd0, 1'b1});
    add_known(8'hFF, 8'hFF, 8'hFF, '{8'd235, 25'd0, 1'b1, 8'd128, 8'd128, 24'd0, 24'd0, 1'b1});
    // Oversize width and height clamp to the caps
    add_wr(REG_FRAME_WIDTH, 8191);
    add_wr(REG_FRAME_HEIGHT, 4097);
    add_px(8'hC3, 8'h3C, 8'h99);
    add_px(8'h66, 8'hE7, 8'h18);
    // 2x3 frame with extreme strides; starts past the new width
    add_wr(REG_FRAME_WIDTH, 2);
    add_wr(REG_FRAME_HEIGHT, 3);
    add_wr(REG_LUMA_STRIDE, 16383);
    add_wr(REG_CB_STRIDE, 8191);
    add_wr(REG_CR_STRIDE, 1);
    add_px(8'h10, 8'h20, 8'h30);
    add_px(8'hF0, 8'hE0, 8'hD0);
    add_px(8'h0F, 8'h1E, 8'h2D);
    add_px(8'hA5, 8'h5A, 8'hA5);
    add_px(8'h5A, 8'hA5, 8'h5A);
    add_px(8'hFF, 8'h00, 8'hFF);

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    prev_write = 1'b0;
    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        if (!prev_write) drain_pipe();
        write_reg(script[i].idx, script[i].data);
        prev_write = 1'b1;
      end else begin
        if (prev_write) cfg_we <= 1'b0;
        offer_pixel(script[i].r, script[i].g, script[i].b, script[i].known, script[i].want);
        prev_write = 1'b0;
      end
    end

    // Random phases; the first walks a tall 1-wide frame for large addresses
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) program_frame(1, 4096, 16383, 8191, 8191);
      else        program_frame(pick_size(), pick_size(), pick_stride(), pick_stride(),
                                pick_stride());
      mode = flow_mode_t'(p % 4);
      case (mode)
        FLOW_FREE: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        FLOW_SENDER_IDLE: begin
          idle_pct  = 68;
          stall_pct = 0;
        end
        FLOW_RECEIVER_STALL: begin
          idle_pct  = 0;
          stall_pct = 68;
        end
        default: begin
          idle_pct  = 14;
          stall_pct = 14;
        end
      endcase
      // long hold-off on the result side while pixels keep coming,
      // so the block fills and drops in ready
      if (p == HOLD_PHASE) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == PAUSE_PHASE && n == PHASE_ITEMS / 2) drain_pipe();
        offer_pixel(pick_channel(), pick_channel(), pick_channel(), 1'b0, '0);
      end
    end

    drain_pipe();
    if (mismatches == 0) $display("tb: success");
    else                 $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/ycc_pkg.sv
src/ycc_if.sv
src/ycc_cfg.sv
src/ycc_raster.sv
src/ycc_csc.sv
src/ycc_addr.sv
src/rgb_to_ycbcr420_converter_top.sv
bench/tb.sv
